FILE: rtl/core/plc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg - photoperiod light controller shared definitions
// Payload types, register indexes, arithmetic constants, sequencer states
// and the request/response types of the serial divider.
// ----------------------------------------------------------------------------
package plc_pkg;

    // knob and pwm mapping end points
    localparam int KNOB_MIN = 0;
    localparam int KNOB_MAX = 100;
    localparam int PWM_MIN  = 0;
    localparam int PWM_MAX  = 255;

    localparam int BRIGHT_MAX = 100;

    // knob to brightness denominator, kept as sign and magnitude
    localparam int          KNOB_DEN     = KNOB_MAX - KNOB_MIN;
    localparam logic        KNOB_DEN_NEG = (KNOB_DEN < 0);
    localparam logic [15:0] KNOB_DEN_MAG = 16'((KNOB_DEN < 0) ? -KNOB_DEN : KNOB_DEN);

    // triangle slope numerator, kept as sign and magnitude
    localparam int          TRI_DEN     = 2 * PWM_MAX - PWM_MIN;
    localparam logic        TRI_DEN_NEG = (TRI_DEN < 0);
    localparam logic [16:0] TRI_DEN_MAG = 17'((TRI_DEN < 0) ? -TRI_DEN : TRI_DEN);

    // brightness 1..100 spans 99 steps
    localparam logic [15:0] BRIGHT_SPAN = 16'(BRIGHT_MAX - 1);

    localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
    localparam logic [15:0] ONE_SECOND_MS = 16'd1000;
    localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

    // serial divider sizes, dividend width must be even
    localparam int DIV_W  = 34;
    localparam int DVSR_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_ENABLED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOURS_ON      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SETPOINT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SETPOINT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_NORMAL_SEC = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_FAULT_SEC  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATHE_MS    = 3'd7;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [6:0]  knob_position;
    } t_in;

    typedef struct packed {
        logic [7:0]  pwm_level;
        logic        heartbeat_led;
        logic        light_on;
        logic [16:0] seconds_remaining;
        logic        forced_off;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
        logic [DVSR_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HB_GO,
        S_HB_WAIT,
        S_TMR,
        S_REM_GO,
        S_REM_WAIT,
        S_MOD_GO,
        S_MOD_WAIT,
        S_TRI_GO,
        S_TRI_WAIT,
        S_BRT_GO,
        S_BRT_WAIT,
        S_PWM_MUL,
        S_PWM_GO,
        S_PWM_WAIT,
        S_OUT
    } t_state;

endpackage

FILE: rtl/core/plc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_div - serial restoring divider
// Unsigned dividend over divisor, two quotient bits per cycle shifted out of
// the dividend register; done pulses one cycle when quotient and remainder hold.
// ----------------------------------------------------------------------------
module plc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  plc_pkg::t_div_req i_req,
    output plc_pkg::t_div_rsp o_rsp
);
    import plc_pkg::*;

    localparam int ITER  = DIV_W / 2;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [DIV_W-1:0]  r_quo;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVSR_W:0]   t1, t2, d_ext, s1, s2;
    logic              ge1, ge2;
    logic [DVSR_W-1:0] r1, r2;

    // two dependent compare-subtract steps
    always_comb begin
        d_ext = {1'b0, r_dvsr};
        t1    = {r_rem, r_quo[DIV_W-1]};
        ge1   = (t1 >= d_ext);
        s1    = t1 - d_ext;
        r1    = ge1 ? s1[DVSR_W-1:0] : t1[DVSR_W-1:0];
        t2    = {r1, r_quo[DIV_W-2]};
        ge2   = (t2 >= d_ext);
        s2    = t2 - d_ext;
        r2    = ge2 ? s2[DVSR_W-1:0] : t2[DVSR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= i_req.dividend;
            r_rem  <= '0;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-3:0], ge1, ge2};
            r_rem <= r2;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: rtl/core/photoperiod_light_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// photoperiod_light_controller - timed grow light drive with heartbeat
// Takes a millisecond time stamp and a knob reading per transfer and returns
// one result: pwm level, heartbeat led, light state, phase time left and the
// forced-off flag.
// ----------------------------------------------------------------------------
// One item is worked at a time. Its results come from divisions run one
// after another through a single radix-4 serial divider, each launched
// from a GO state and collected in the WAIT state that follows it:
// the heartbeat seconds, the seconds left in the phase, and either the knob
// brightness followed, when lit and nonzero, by the pwm scaling (normal mode) or the
// triangle phase and slope (fault mode). The input side stalls from the
// transfer until the result is loaded into the output register; a result
// still waiting there does not hold off the next item, only the loading of
// its own result. Configuration is written through a plain write port and
// must only change while no item is in flight.
// ----------------------------------------------------------------------------
module photoperiod_light_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  plc_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output plc_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [plc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [plc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import plc_pkg::*;

    // signed constants for the final pwm arithmetic
    localparam logic signed [19:0] TRI_BASE = 20'(PWM_MIN);
    localparam logic signed [19:0] TRI_TOP  = 20'(PWM_MAX);
    localparam logic signed [19:0] TRI_FOLD = 20'(2 * PWM_MAX);
    localparam logic signed [19:0] TRI_SAT  = 20'sd255;
    localparam logic signed [9:0]  PWM_SAT  = 10'sd255;
    localparam logic [6:0]         BRT_TOP  = 7'(BRIGHT_MAX);

    // configuration registers
    logic        r_fault;
    logic        r_timer_en;
    logic [4:0]  r_hours;
    logic [7:0]  r_min_sp;
    logic [7:0]  r_max_sp;
    logic [15:0] r_hb_norm;
    logic [15:0] r_hb_fault;
    logic [15:0] r_breathe;

    // controller state kept across items
    logic        r_le;
    logic [31:0] r_phase;
    logic        r_kwz;
    logic        r_hb_lvl;
    logic [15:0] r_hb_last;

    // per item working registers
    logic [31:0] r_now;
    logic [6:0]  r_knob;
    logic [6:0]  r_bright;
    logic [7:0]  r_pwm;
    logic [16:0] r_rem;
    logic [DIV_W-1:0] r_mul;
    logic        r_neg;

    // output register
    logic        r_out_valid;
    t_out        r_out;

    t_state      r_state, n_state;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic        in_xfer;
    logic        out_load;
    logic        knob_zero;

    // phase lengths
    logic [4:0]  hours_c;
    logic [31:0] on_ms, off_ms;

    // day timer step
    logic        le1, flip;
    logic [31:0] ph1, el1, span1;

    // seconds left
    logic [31:0] span, el, rem_dvd;

    // heartbeat
    logic [15:0] hb_sec, hb_intv;
    logic [16:0] hb_due;
    logic        hb_toggle;

    // knob to brightness
    logic signed [11:0] knob_diff;
    logic        knob_neg;
    logic [10:0] knob_mag;
    logic [17:0] knob_num;
    logic [6:0]  bright_c;

    // brightness to pwm
    logic signed [8:0]  sp_diff;
    logic [8:0]  sp_neg_diff;
    logic [7:0]  sp_mag;
    logic [6:0]  bright_m1;
    logic [14:0] pwm_prod;
    logic signed [9:0]  pwm_q, pwm_v;
    logic [7:0]  pwm_c;

    // triangle
    logic [15:0] period;
    logic [32:0] tri_prod;
    logic signed [19:0] tri_q, tri_v, tri_f;
    logic [7:0]  tri_c;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign knob_zero  = (r_knob == 7'd0);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // hours above a day count as a whole day
    assign hours_c = (r_hours > HOURS_PER_DAY) ? HOURS_PER_DAY : r_hours;
    assign on_ms   = {27'd0, hours_c} * MS_PER_HOUR;
    assign off_ms  = {27'd0, 5'(HOURS_PER_DAY - hours_c)} * MS_PER_HOUR;

    // knob leaving zero restarts an on phase, then the phase may expire
    always_comb begin
        le1   = r_kwz ? 1'b1 : r_le;
        ph1   = r_kwz ? r_now : r_phase;
        el1   = r_now - ph1;
        span1 = le1 ? on_ms : off_ms;
        flip  = (el1 >= span1);
    end

    // time left in the phase, zero when forced off or expired
    always_comb begin
        span    = r_le ? on_ms : off_ms;
        el      = r_now - r_phase;
        rem_dvd = (!knob_zero && (span > el)) ? (span - el) : 32'd0;
    end

    // heartbeat, sum taken one bit wider so it never wraps
    always_comb begin
        hb_sec    = div_rsp.quo[15:0];
        hb_intv   = r_fault ? r_hb_fault : r_hb_norm;
        hb_due    = {1'b0, r_hb_last} + {1'b0, hb_intv};
        hb_toggle = ({1'b0, hb_sec} >= hb_due);
    end

    // knob offset as sign and magnitude, brightness clamps negatives to zero
    always_comb begin
        knob_diff = $signed({5'd0, r_knob}) - 12'(KNOB_MIN);
        knob_neg  = knob_diff[11];
        knob_mag  = knob_neg ? 11'(-knob_diff) : knob_diff[10:0];
        knob_num  = knob_mag * 7'd100;
        if (r_neg) begin
            bright_c = 7'd0;
        end else if (div_rsp.quo > DIV_W'(BRIGHT_MAX)) begin
            bright_c = BRT_TOP;
        end else begin
            bright_c = div_rsp.quo[6:0];
        end
    end

    // brightness 1..100 onto the setpoint span
    always_comb begin
        sp_diff     = $signed({1'b0, r_max_sp}) - $signed({1'b0, r_min_sp});
        sp_neg_diff = 9'(-sp_diff);
        sp_mag      = sp_diff[8] ? sp_neg_diff[7:0] : sp_diff[7:0];
        bright_m1   = r_bright - 7'd1;
        pwm_prod    = bright_m1 * sp_mag;
        pwm_q       = $signed({2'b00, div_rsp.quo[7:0]});
        pwm_v       = $signed({2'b00, r_min_sp}) + (r_neg ? -pwm_q : pwm_q);
        if (pwm_v < 10'sd0) begin
            pwm_c = 8'd0;
        end else if (pwm_v > PWM_SAT) begin
            pwm_c = 8'hFF;
        end else begin
            pwm_c = pwm_v[7:0];
        end
    end

    // triangle: rising to twice the top, then folded back down
    always_comb begin
        period   = (r_breathe == 16'd0) ? 16'd1 : r_breathe;
        tri_prod = div_rsp.rem * TRI_DEN_MAG;
        tri_q    = $signed({2'b00, div_rsp.quo[17:0]});
        tri_v    = TRI_BASE + (r_neg ? -tri_q : tri_q);
        tri_f    = (tri_v > TRI_TOP) ? (TRI_FOLD - tri_v) : tri_v;
        if (tri_f < 20'sd0) begin
            tri_c = 8'd0;
        end else if (tri_f > TRI_SAT) begin
            tri_c = 8'hFF;
        end else begin
            tri_c = tri_f[7:0];
        end
    end

    // sequencer next state and divider launch
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = ONE_SECOND_MS;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_HB_GO;
            end
            S_HB_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(r_now);
                n_state          = S_HB_WAIT;
            end
            S_HB_WAIT: begin
                if (div_rsp.done) n_state = S_TMR;
            end
            S_TMR: begin
                n_state = S_REM_GO;
            end
            S_REM_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(rem_dvd);
                n_state          = S_REM_WAIT;
            end
            S_REM_WAIT: begin
                if (div_rsp.done) begin
                    if (r_fault) begin
                        n_state = S_MOD_GO;
                    end else if (KNOB_DEN_MAG == 16'd0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_BRT_GO;
                    end
                end
            end
            S_MOD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(r_now);
                div_req.divisor  = period;
                n_state          = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (div_rsp.done) n_state = S_TRI_GO;
            end
            S_TRI_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_mul;
                div_req.divisor  = period;
                n_state          = S_TRI_WAIT;
            end
            S_TRI_WAIT: begin
                if (div_rsp.done) n_state = S_OUT;
            end
            S_BRT_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(knob_num);
                div_req.divisor  = KNOB_DEN_MAG;
                n_state          = S_BRT_WAIT;
            end
            S_BRT_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_le && (bright_c != 7'd0)) ? S_PWM_MUL : S_OUT;
                end
            end
            S_PWM_MUL: begin
                n_state = S_PWM_GO;
            end
            S_PWM_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_mul;
                div_req.divisor  = BRIGHT_SPAN;
                n_state          = S_PWM_WAIT;
            end
            S_PWM_WAIT: begin
                if (div_rsp.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes, every index of the port selects one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault    <= 1'b0;
            r_timer_en <= 1'b1;
            r_hours    <= 5'd12;
            r_min_sp   <= 8'd0;
            r_max_sp   <= 8'd255;
            r_hb_norm  <= 16'd1;
            r_hb_fault <= 16'd1;
            r_breathe  <= 16'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FAULT_MODE:    r_fault    <= i_cfg_data[0];
                CFG_TIMER_ENABLED: r_timer_en <= i_cfg_data[0];
                CFG_HOURS_ON:      r_hours    <= i_cfg_data[4:0];
                CFG_MIN_SETPOINT:  r_min_sp   <= i_cfg_data[7:0];
                CFG_MAX_SETPOINT:  r_max_sp   <= i_cfg_data[7:0];
                CFG_HB_NORMAL_SEC: r_hb_norm  <= i_cfg_data;
                CFG_HB_FAULT_SEC:  r_hb_fault <= i_cfg_data;
                CFG_BREATHE_MS:    r_breathe  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state kept across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_le      <= 1'b1;
            r_phase   <= 32'd0;
            r_kwz     <= 1'b0;
            r_hb_lvl  <= 1'b0;
            r_hb_last <= 16'd0;
        end else begin
            if ((r_state == S_HB_WAIT) && div_rsp.done && hb_toggle) begin
                r_hb_lvl  <= !r_hb_lvl;
                r_hb_last <= hb_sec;
            end
            // day timer runs only in normal mode with the timer on
            if ((r_state == S_TMR) && !r_fault && r_timer_en) begin
                r_kwz <= knob_zero;
                if (knob_zero) begin
                    r_le    <= 1'b0;
                    r_phase <= r_now;
                end else if (flip) begin
                    r_le    <= !le1;
                    r_phase <= r_now;
                end else begin
                    r_le    <= le1;
                    r_phase <= ph1;
                end
            end
        end
    end

    // per item datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_now  <= i_in_data.now_ms;
                r_knob <= i_in_data.knob_position;
                r_pwm  <= 8'd0;
            end
            S_REM_WAIT: begin
                if (div_rsp.done) r_rem <= div_rsp.quo[16:0];
            end
            S_MOD_WAIT: begin
                // phase within the period times the slope, registered
                r_mul <= DIV_W'(tri_prod);
                r_neg <= TRI_DEN_NEG;
            end
            S_TRI_WAIT: begin
                if (div_rsp.done) r_pwm <= tri_c;
            end
            S_BRT_GO: begin
                r_neg <= knob_neg ^ KNOB_DEN_NEG;
            end
            S_BRT_WAIT: begin
                r_bright <= bright_c;
            end
            S_PWM_MUL: begin
                r_mul <= DIV_W'(pwm_prod);
                r_neg <= sp_diff[8];
            end
            S_PWM_WAIT: begin
                if (div_rsp.done) r_pwm <= pwm_c;
            end
            default: ;
        endcase
    end

    // output register, refilled once the waiting result is transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.pwm_level         <= r_pwm;
            r_out.heartbeat_led     <= r_hb_lvl;
            r_out.light_on          <= r_le;
            r_out.seconds_remaining <= r_rem;
            r_out.forced_off        <= knob_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    plc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // divider only finishes while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_HB_WAIT || r_state == S_REM_WAIT ||
                          r_state == S_MOD_WAIT || r_state == S_TRI_WAIT ||
                          r_state == S_BRT_WAIT || r_state == S_PWM_WAIT))
        else $error("divider done outside a wait state");

    // an input transfer always starts the heartbeat division
    a_xfer_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_HB_GO))
        else $error("input transfer did not start the sequence");

    // a forced-off result reports no time left
    a_forced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.forced_off) |-> (o_out_data.seconds_remaining == 17'd0))
        else $error("forced-off result with time remaining");

endmodule
